// ===== hdl/positional_insert_list_defines.svh =====
// Assertion macros shared by the RTL of the positional insert list.
`ifndef POSITIONAL_INSERT_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_LIST_DEFINES_SVH

// Concurrent check sampled on the rising clock, off while reset is asserted.
`define PIL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold at a sampled clock edge.
`define PIL_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/pil_pkg.sv =====
// Shared codes and types of the positional insert list.
package pil_pkg;

	// Operation carried by an input transaction.
	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_REMOVE = 1'b1
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

endpackage

// ===== hdl/positional_insert_list.sv =====
// Positional insert list: a bounded ordered list held in a memory and shifted by a sequencer.
//
//   channel   direction  handshake             payload
//   command   in         start while !busy     kind, position, value
//   result    out        done (one cycle)      status, removed_value, length
//
// A refused transaction (full list, position beyond the length, remove from
// an empty list) is answered by done in the cycle after it is accepted, and
// busy stays low. A good insert moves each entry from position p to the tail
// one place back and then writes the new value (S_PUT); a good remove moves
// every entry behind the head one place forward. Each entry moved takes a read
// step (S_RD) and a write step (S_WR) through the single memory port pair. done
// rises as busy falls, and a new command can be taken in the same cycle done is high.
// Reset clears the entry count and the sequencer; the memory keeps no reset.
// The receiver cannot stall; each result is present for exactly one cycle.
`include "positional_insert_list_defines.svh"

module positional_insert_list #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [7:0]  position,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] removed_value,
	output logic [4:0]  length
);

	// Address width of the entry memory and width of the entry count.
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_WR   = 4'b0100,
		S_PUT  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         idx_q;
	logic [AW-1:0]         pos_q;
	logic [31:0]           val_q;
	pil_pkg::kind_t        kind_q;
	logic [31:0]           rd_q;
	logic [31:0]           head_q;
	logic                  done_q;
	pil_pkg::status_t      status_q;
	logic [31:0]           removed_q;

	// The entries live in a single-port-write, single-port-read memory.
	logic [31:0]           mem [CAPACITY];

	logic                  full;
	logic                  pos_bad;
	logic [AW-1:0]         idx_dn;
	logic                  rm_last;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [31:0]           wr_data;
	logic [CW+4:0]         count_ext;

	assign full    = (count_q == CW'(CAPACITY));
	assign pos_bad = (position > 8'(count_q));
	assign idx_dn  = idx_q - AW'(1);
	// During a remove, rm_last marks that the entry at idx_q is the last one to move forward.
	assign rm_last = ((CW'(idx_q) + CW'(1)) == count_q);

	// An insert reads the entry just ahead of the slot being filled; a remove
	// reads the entry that moves one place toward the front.
	always_comb begin
		if (kind_q == pil_pkg::KIND_INSERT) begin
			rd_addr = idx_dn;
		end else begin
			rd_addr = idx_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q;
		case (state_q)
			S_WR: begin
				if (kind_q == pil_pkg::KIND_INSERT) begin
					wr_en   = 1'b1;
					wr_addr = idx_q;
				end else begin
					// The head is captured, not written, when idx_q is zero.
					wr_en   = (idx_q != '0);
					wr_addr = idx_dn;
				end
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = val_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			rd_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Result payload; sampled by the receiver only while done is high.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					pos_q  <= position[AW-1:0];
					val_q  <= value;
					kind_q <= pil_pkg::kind_t'(kind);
					if (kind == pil_pkg::KIND_INSERT) begin
						idx_q <= count_q[AW-1:0];
					end else begin
						idx_q <= '0;
					end
					removed_q <= '0;
					if (kind == pil_pkg::KIND_INSERT) begin
						if (full) begin
							status_q <= pil_pkg::ST_FULL;
						end else if (pos_bad) begin
							status_q <= pil_pkg::ST_BAD_POS;
						end
					end else if (count_q == '0) begin
						status_q <= pil_pkg::ST_EMPTY;
					end
				end
			end
			S_WR: begin
				if (kind_q == pil_pkg::KIND_INSERT) begin
					idx_q <= idx_dn;
				end else begin
					if (idx_q == '0) begin
						head_q <= rd_q;
					end
					if (rm_last) begin
						status_q  <= pil_pkg::ST_OK;
						removed_q <= (idx_q == '0) ? rd_q : head_q;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
			end
			S_PUT: begin
				status_q  <= pil_pkg::ST_OK;
				removed_q <= '0;
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	// Sequencer and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (kind == pil_pkg::KIND_INSERT) begin
							if (full || pos_bad) begin
								done_q <= 1'b1;
							end else if (count_q[AW-1:0] == position[AW-1:0]) begin
								state_q <= S_PUT;
							end else begin
								state_q <= S_RD;
							end
						end else if (count_q == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					if (kind_q == pil_pkg::KIND_INSERT) begin
						state_q <= (idx_dn == pos_q) ? S_PUT : S_RD;
					end else if (rm_last) begin
						count_q <= count_q - CW'(1);
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The count already holds the post-operation length when done is high.
	assign count_ext     = (CW + 5)'(count_q);
	assign length        = count_ext[4:0];
	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign removed_value = removed_q;

	`PIL_NEVER(a_count_bound, count_q > CW'(CAPACITY), "entry count above capacity")
	`PIL_ASSERT(a_accept_answered, start && !busy |=> done || busy, "transaction neither answered nor in progress")
	`PIL_ASSERT(a_full_len, done && status == pil_pkg::ST_FULL |-> count_q == CW'(CAPACITY), "full status with room left")
	`PIL_ASSERT(a_empty_res, done && status == pil_pkg::ST_EMPTY |-> count_q == '0 && removed_value == '0, "empty status with entries or a value")
	`PIL_ASSERT(a_done_idle, done |-> !$past(busy) || $past(state_q) == S_PUT || $past(state_q) == S_WR, "result without finishing step")

endmodule

// ===== sim/positional_insert_list_checker.sv =====
// Checker of the positional insert list: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module positional_insert_list_checker #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        kind,
	input  logic [7:0]  position,
	input  logic [31:0] value,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [31:0] removed_value,
	input  logic [4:0]  length,
	output int          mismatches,
	output int          outstanding,
	output int          held
);

	typedef struct packed {
		pil_pkg::status_t status;
		logic [31:0]      removed_value;
		logic [4:0]       length;
	} list_result_t;

	logic [31:0]  cells [CAPACITY];
	int           count;
	list_result_t awaited [$];
	list_result_t want;

	// Applies one command to the predicted list and returns the result it should give.
	function automatic list_result_t apply_command(pil_pkg::kind_t op, logic [7:0] pos,
			logic [31:0] val);
		list_result_t r;
		int i;
		r.removed_value = '0;
		if (op == pil_pkg::KIND_INSERT) begin
			if (count >= CAPACITY) begin
				r.status = pil_pkg::ST_FULL;
			end else if (int'(pos) > count) begin
				r.status = pil_pkg::ST_BAD_POS;
			end else begin
				for (i = count; i > int'(pos); i--)
					cells[i] = cells[i - 1];
				cells[pos] = val;
				count++;
				r.status = pil_pkg::ST_OK;
			end
		end else if (count == 0) begin
			r.status = pil_pkg::ST_EMPTY;
		end else begin
			r.removed_value = cells[0];
			for (i = 1; i < count; i++)
				cells[i - 1] = cells[i];
			count--;
			r.status = pil_pkg::ST_OK;
		end
		r.length = 5'(count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count = 0;
			mismatches = 0;
			awaited.delete();
		end else begin
			if (done === 1'b1) begin
				if (awaited.size() == 0) begin
					mismatches++;
					$error("result with no transaction waiting: status %0d length %0d",
						status, length);
				end else begin
					want = awaited.pop_front();
					if (status !== want.status) begin
						mismatches++;
						$error("status: expected %0d, got %0d", want.status, status);
					end
					if (removed_value !== want.removed_value) begin
						mismatches++;
						$error("removed_value: expected %0d, got %0d",
							$signed(want.removed_value), $signed(removed_value));
					end
					if (length !== want.length) begin
						mismatches++;
						$error("length: expected %0d, got %0d", want.length, length);
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				awaited.push_back(apply_command(pil_pkg::kind_t'(kind), position, value));
		end
		outstanding = awaited.size();
		held = count;
	end

endmodule

// ===== sim/positional_insert_list_test.sv =====
// Testbench top of the positional insert list: stimulus, reset, timeout and verdict.
`timescale 1ns / 1ps

module positional_insert_list_test;

	localparam int CAPACITY     = 16;
	// LIMIT_CYCLES bounds the whole run, the sender's gaps included; the 1351
	// transactions stay far below this bound.
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS  = 442;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [7:0]  position;
	logic [31:0] value;
	logic        done;
	logic [1:0]  status;
	logic [31:0] removed_value;
	logic [4:0]  length;

	int mismatches;
	int outstanding;
	int held;
	int cycles;
	int idle_pct;
	int insert_pct;

	positional_insert_list #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.position(position),
		.value(value),
		.done(done),
		.status(status),
		.removed_value(removed_value),
		.length(length)
	);

	// The checker sees every channel, keeps its own copy of the list and
	// reports the mismatch count, the results still owed and the list length.
	positional_insert_list_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.position(position),
		.value(value),
		.done(done),
		.status(status),
		.removed_value(removed_value),
		.length(length),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.held(held)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Timeout guard: a hung handshake or a missing result ends up here.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("FAIL positional_insert_list");
			$finish;
		end
	end

	// Sends one transaction. It is entered just after a falling edge and
	// returns just after the falling edge that follows acceptance, so the
	// caller always sees the checker's list length for the updated list.
	// Before the transaction the sender may idle for a random number of
	// cycles, one idle chance of idle_pct percent per cycle.
	task automatic issue(input pil_pkg::kind_t op, input logic [7:0] pos,
			input logic [31:0] val);
		int gap;
		gap = 0;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    <= 1'b1;
		kind     <= op;
		position <= pos;
		value    <= val;
		// The transaction is taken at the first rising edge with busy low.
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	// Holds the sender off until every result owed has come back.
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Picks a value with the extremes of the signed range well represented.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(19))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	// One random transaction. Most inserts name a position within the list,
	// with the head and the tail favored; the rest go beyond the length or
	// anywhere in the 8-bit range. Removes carry random ignored fields.
	task automatic random_item();
		pil_pkg::kind_t op;
		logic [7:0]     pos;
		int             pick;
		op = ($urandom_range(99) < insert_pct) ? pil_pkg::KIND_INSERT : pil_pkg::KIND_REMOVE;
		pick = $urandom_range(99);
		if (pick < 66)
			pos = 8'($urandom_range(held));
		else if (pick < 76)
			pos = 8'd0;
		else if (pick < 86)
			pos = 8'(held);
		else if (pick < 94)
			pos = 8'($urandom_range(255, held + 1));
		else
			pos = 8'($urandom_range(255));
		issue(op, pos, pick_value());
	endtask

	initial begin
		int phase;
		int n;

		// Every input is known from time zero; reset is released on a falling
		// edge, once for the whole run.
		arst_n     = 1'b0;
		start      = 1'b0;
		kind       = pil_pkg::KIND_INSERT;
		position   = '0;
		value      = '0;
		idle_pct   = 0;
		insert_pct = 50;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: the refusals on an empty list, the extremes of the
		// value, inserts at the head, in the middle and at the tail, a
		// position just past the length, filling the list, inserts into a
		// full list at both ends of the position range, and removes.
		issue(pil_pkg::KIND_REMOVE, 8'd0, 32'h1234_5678);
		issue(pil_pkg::KIND_INSERT, 8'd1, 32'h0000_0001);
		issue(pil_pkg::KIND_INSERT, 8'd255, 32'h0000_0002);
		issue(pil_pkg::KIND_INSERT, 8'd0, 32'h8000_0000);
		issue(pil_pkg::KIND_INSERT, 8'd1, 32'h7FFF_FFFF);
		issue(pil_pkg::KIND_INSERT, 8'd0, 32'hFFFF_FFFF);
		issue(pil_pkg::KIND_INSERT, 8'd1, 32'h0000_0000);
		issue(pil_pkg::KIND_INSERT, 8'd5, 32'hDEAD_BEEF);
		issue(pil_pkg::KIND_REMOVE, 8'hFF, 32'hFFFF_FFFF);
		issue(pil_pkg::KIND_INSERT, 8'd3, 32'h5A5A_A5A5);
		while (held < CAPACITY)
			issue(pil_pkg::KIND_INSERT, 8'($urandom_range(held)), $urandom());
		issue(pil_pkg::KIND_INSERT, 8'd0, 32'h0BAD_F00D);
		issue(pil_pkg::KIND_INSERT, 8'd255, 32'hFFFF_0000);
		issue(pil_pkg::KIND_REMOVE, 8'd0, 32'h0000_0000);
		drain();

		// Random part in three phases: the sender idles 18 percent of the
		// time, then 72 percent, then never. The insert share is redrawn
		// every 40 transactions so the list swings between empty and full.
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 18 : (phase == 1) ? 72 : 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					insert_pct = 30 + 25 * $urandom_range(2);
				if (n == PHASE_ITEMS / 2)
					drain();
				random_item();
			end
			drain();
		end

		// All stimulus is in and every result has come; give the block time
		// to show any stray result before the verdict.
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("PASS positional_insert_list");
		else
			$display("FAIL positional_insert_list");
		$finish;
	end

endmodule
